// File: rtl/scan_polar_to_cartesian_filter_core_macros.svh
// Assertion macros shared by the scan filter RTL.
`ifndef SCAN_POLAR_TO_CARTESIAN_FILTER_CORE_MACROS_SVH
`define SCAN_POLAR_TO_CARTESIAN_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPCF_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPCF_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/spcf_pkg.sv
// Types, constants and the arctangent table of the scan filter.
package spcf_pkg;

  localparam int MAX_BEAMS_DEF    = 4096;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int RANGE_W    = 16;
  localparam int ANG_W      = 20;
  localparam int ANGSUM_W   = 21;  // heading + beam angle
  localparam int CW_W       = 16;
  localparam int COORD_W    = 24;
  localparam int BIDX_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ANG_SHIFT  = 14;  // Q16 -> Q30
  localparam int Z_W        = 36;
  localparam int XY_W       = 34;
  localparam int PROD_W     = RANGE_W + 1 + XY_W;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [Z_W-1:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] NEG_PI_Q30   = -36'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [Z_W-1:0] NEG_HALF_PI_Q30 = -36'sd1686629713;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30   = 36'sd6746518852;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRIDOR_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z       = 3'd6;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               first_of_scan;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      kept;
    logic [BIDX_W-1:0]         beam_index;
  } out_item_t;

  typedef struct packed {
    logic start;
  } cord_ctl_t;

  typedef struct packed {
    logic done;
  } cord_sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START1, S_CORD1, S_MX1, S_MY1, S_FILT,
    S_CORD2, S_MX2, S_MY2, S_PY, S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_REDUCE, C_FOLD, C_ITER, C_DONE
  } cord_state_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/spcf_mul.sv
// Registered range by trig multiplier shared across the four products.
module spcf_mul import spcf_pkg::*; (
  input  logic                     clk,
  input  logic [RANGE_W-1:0]       range_mm,
  input  logic signed [XY_W-1:0]   trig,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, range_mm}) * trig;
  end

  assign prod = prod_r;

endmodule

// File: rtl/spcf_cordic.sv
// Iterative CORDIC rotator: angle reduction, quadrant fold, one micro-rotation a cycle.
`include "scan_polar_to_cartesian_filter_core_macros.svh"
module spcf_cordic import spcf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cord_ctl_t              ctl,
  input  logic signed [ANGSUM_W-1:0] ang_q16,
  output cord_sts_t              sts,
  output logic signed [XY_W-1:0] cos_q30,
  output logic signed [XY_W-1:0] sin_q30
);

  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  cord_state_t state_r, state_nxt;

  logic signed [Z_W-1:0]  z_r;
  logic signed [XY_W-1:0] x_r, y_r;
  logic                   flip_r;
  logic [ITER_W-1:0]      iter_r;

  logic signed [Z_W-1:0]  z_load;
  logic                   z_hi, z_lo, z_hhi, z_hlo;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atan_z;
  logic                   last_iter;

  assign z_load = {{(Z_W-ANGSUM_W-ANG_SHIFT){ang_q16[ANGSUM_W-1]}}, ang_q16,
                   {ANG_SHIFT{1'b0}}};
  assign z_hi   = (z_r > PI_Q30);
  assign z_lo   = (z_r < NEG_PI_Q30);
  assign z_hhi  = (z_r > HALF_PI_Q30);
  assign z_hlo  = (z_r < NEG_HALF_PI_Q30);
  assign dx     = y_r >>> iter_r;
  assign dy     = x_r >>> iter_r;
  assign atan_z = $signed({{(Z_W-32){1'b0}}, atan_q30(ATAN_IDX_W'(iter_r))});
  assign last_iter = (iter_r == ITER_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sts.done  = 1'b0;
    unique case (state_r)
      C_IDLE:   if (ctl.start) state_nxt = C_REDUCE;
      C_REDUCE: if (!z_hi && !z_lo) state_nxt = C_FOLD;
      C_FOLD:   state_nxt = C_ITER;
      C_ITER:   if (last_iter) state_nxt = C_DONE;
      C_DONE: begin
        sts.done  = 1'b1;
        state_nxt = C_IDLE;
      end
      default:  state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      C_IDLE: begin
        if (ctl.start) begin
          z_r    <= z_load;
          x_r    <= CORDIC_GAIN_Q30;
          y_r    <= '0;
          flip_r <= 1'b0;
          iter_r <= '0;
        end
      end
      C_REDUCE: begin
        if (z_hi)      z_r <= z_r - TWO_PI_Q30;
        else if (z_lo) z_r <= z_r + TWO_PI_Q30;
      end
      C_FOLD: begin
        if (z_hhi) begin
          z_r    <= z_r - PI_Q30;
          flip_r <= 1'b1;
        end else if (z_hlo) begin
          z_r    <= z_r + PI_Q30;
          flip_r <= 1'b1;
        end
      end
      C_ITER: begin
        if (!z_r[Z_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_z;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_z;
        end
        iter_r <= iter_r + ITER_W'(1);
      end
      default: ;
    endcase
  end

  // results hold until the next start
  assign cos_q30 = flip_r ? -x_r : x_r;
  assign sin_q30 = flip_r ? -y_r : y_r;

  `SPCF_ASSERT_IMP(a_fold_range, clk, rst_n, (state_r == C_ITER && iter_r == '0),
    (z_r <= HALF_PI_Q30 && z_r >= NEG_HALF_PI_Q30), "angle not folded to +-pi/2")
  `SPCF_ASSERT_IMP(a_start_idle, clk, rst_n, ctl.start, (state_r == C_IDLE),
    "CORDIC started while busy")

endmodule

// File: rtl/scan_polar_to_cartesian_filter_core.sv
// Top level of the laser scan polar-to-cartesian corridor filter. Each input
// transaction carries one range sample; the block updates its running beam angle
// and beam index (restarting on first_of_scan), rotates the beam through an
// iterative CORDIC to get the local forward and lateral offsets, applies the
// corridor filter (off when corridor_width is zero), and for a kept point runs a
// second rotation by heading plus beam angle, adds the origin and saturates to
// 24 bits. Exactly one result transaction follows every input transaction; a
// dropped point has zero x and y. One shared CORDIC unit and one shared
// 17x34 multiplier do all the work, so one sample is in flight at a time and
// in_stall stays high from acceptance until the result is loaded into the
// output register. A CORDIC pass reduces the angle by two pi as often as needed
// (at most once for the beam angle, at most three times for heading plus beam
// angle), folds it to +-pi/2 and then runs CORDIC_STEPS micro-rotations. A
// finished sample may wait in S_OUT on out_stall while an earlier result is still
// held. The output register lets a new sample be accepted while the previous
// result waits. cfg_ready is always high; registers must be written only while
// the block is idle.
`include "scan_polar_to_cartesian_filter_core_macros.svh"
module scan_polar_to_cartesian_filter_core import spcf_pkg::*; #(
  parameter int MAX_BEAMS    = MAX_BEAMS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_BEAMS);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd536870912);
  localparam int MM_W = PROD_W - 30;

  // configuration registers
  logic signed [ANG_W-1:0]   angle_start_r, angle_step_r, heading_r;
  logic [CW_W-1:0]           corridor_width_r;
  logic signed [COORD_W-1:0] origin_x_r, origin_y_r, origin_z_r;

  // scan state
  logic signed [ANG_W-1:0]   beam_angle_r;
  logic [CNT_W-1:0]          beam_count_r;

  // per-sample working registers
  seq_state_t                state_r, state_nxt;
  logic [RANGE_W-1:0]        range_r;
  logic                      lx_neg_r;
  logic                      kept_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  // shared units
  cord_ctl_t                 cord_ctl;
  cord_sts_t                 cord_sts;
  logic signed [ANGSUM_W-1:0] cord_ang;
  logic signed [XY_W-1:0]    cos_q30, sin_q30, trig;
  logic signed [PROD_W-1:0]  prod;

  logic                      in_acc, out_load;
  logic [PROD_W-1:0]         aly, half_w;
  logic                      keep_now;
  logic signed [ANGSUM_W-1:0] ang_beam, ang_map;

  // product (Q30) to mm with round half up, plus origin, saturated to 24 bits
  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [PROD_W-1:0]  p,
    input logic signed [COORD_W-1:0] org
  );
    logic signed [PROD_W-1:0]  pr;
    logic signed [MM_W-1:0]    mm;
    logic signed [COORD_W+1:0] s;
    logic signed [COORD_W-1:0] r;
    pr = p + RND_HALF;
    mm = pr[PROD_W-1:30];
    s  = {{2{org[COORD_W-1]}}, org} + {{(COORD_W+2-MM_W){mm[MM_W-1]}}, mm};
    if (s[COORD_W+1:COORD_W-1] == 3'b000 || s[COORD_W+1:COORD_W-1] == 3'b111) begin
      r = s[COORD_W-1:0];
    end else if (s[COORD_W+1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  assign ang_beam = {beam_angle_r[ANG_W-1], beam_angle_r};
  assign ang_map  = {heading_r[ANG_W-1], heading_r} + ang_beam;

  // corridor test on the lateral product, exact in Q30; a negative forward offset also drops
  assign aly      = prod[PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
  assign half_w   = {{(PROD_W-CW_W-29){1'b0}}, corridor_width_r, 29'b0};
  assign keep_now = (corridor_width_r == '0) || !((aly > half_w) || lx_neg_r);

  spcf_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cord_ctl),
    .ang_q16 (cord_ang),
    .sts     (cord_sts),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  spcf_mul u_mul (
    .clk      (clk),
    .range_mm (range_r),
    .trig     (trig),
    .prod     (prod)
  );

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r    <= '0;
      angle_step_r     <= '0;
      heading_r        <= '0;
      corridor_width_r <= '0;
      origin_x_r       <= '0;
      origin_y_r       <= '0;
      origin_z_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANGLE_START:    angle_start_r    <= cfg_data[ANG_W-1:0];
        CFG_ANGLE_STEP:     angle_step_r     <= cfg_data[ANG_W-1:0];
        CFG_HEADING:        heading_r        <= cfg_data[ANG_W-1:0];
        CFG_CORRIDOR_WIDTH: corridor_width_r <= cfg_data[CW_W-1:0];
        CFG_ORIGIN_X:       origin_x_r       <= cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Y:       origin_y_r       <= cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Z:       origin_z_r       <= cfg_data[COORD_W-1:0];
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  // beam angle and index advance on each accepted transaction, restarting on first_of_scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= '0;
      beam_count_r <= '0;
    end else if (in_acc) begin
      if (in_data.first_of_scan) begin
        beam_angle_r <= angle_start_r;
        beam_count_r <= '0;
      end else begin
        beam_angle_r <= beam_angle_r + angle_step_r;  // wraps in 20 bits
        beam_count_r <= (beam_count_r == CNT_W'(MAX_BEAMS - 1)) ? '0
                        : beam_count_r + CNT_W'(1);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cord_ctl.start = 1'b0;
    cord_ang       = ang_beam;
    trig           = sin_q30;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_START1;
      S_START1: begin
        cord_ctl.start = 1'b1;
        state_nxt      = S_CORD1;
      end
      S_CORD1:  if (cord_sts.done) state_nxt = S_MX1;
      S_MX1: begin
        trig      = cos_q30;
        state_nxt = S_MY1;
      end
      S_MY1:    state_nxt = S_FILT;
      S_FILT: begin
        // second rotation only for kept points
        cord_ang       = ang_map;
        cord_ctl.start = keep_now;
        state_nxt      = keep_now ? S_CORD2 : S_OUT;
      end
      S_CORD2: begin
        cord_ang = ang_map;
        if (cord_sts.done) state_nxt = S_MX2;
      end
      S_MX2: begin
        trig      = cos_q30;
        state_nxt = S_MY2;
      end
      S_MY2:    state_nxt = S_PY;
      S_PY:     state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (in_acc) range_r <= in_data.range_mm;
    unique case (state_r)
      S_MY1:  lx_neg_r <= prod[PROD_W-1];
      S_FILT: begin
        kept_r <= keep_now;
        if (!keep_now) begin
          px_r <= '0;
          py_r <= '0;
        end
      end
      S_MY2:  px_r <= round_sat(prod, origin_x_r);
      S_PY:   py_r <= round_sat(prod, origin_y_r);
      default: ;
    endcase
  end

  // output register: holds a finished result while the next sample is worked on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.point_x    <= px_r;
      out_data_r.point_y    <= py_r;
      out_data_r.point_z    <= origin_z_r;
      out_data_r.kept       <= kept_r;
      out_data_r.beam_index <= BIDX_W'(beam_count_r);
    end
  end

  `SPCF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall,
    "sample accepted but block not busy next cycle")
  `SPCF_ASSERT_NXT(a_result_loaded, clk, rst_n, out_load, out_valid,
    "result load did not raise out_valid")
  `SPCF_ASSERT_IMP(a_drop_zero, clk, rst_n, (out_valid && !out_data.kept),
    (out_data.point_x == '0 && out_data.point_y == '0), "dropped point with coordinates")

endmodule
